// File: hdl/dgh_pkg.sv
`default_nettype none

package dgh_pkg;

   typedef enum logic [1:0] {
      OP_ACCESS = 2'd0,
      OP_HEADER = 2'd1,
      OP_FORMAT = 2'd2
   } operation_type;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_RANGE  = 2'd1;
   localparam logic [1:0] STATUS_NOSIZE = 2'd2;

   localparam logic CSR_SECTOR_SIZE = 1'b0;
   localparam logic CSR_DATA_OFFSET = 1'b1;

   localparam logic [15:0] SECTOR_SIZE_RESET = 16'd512;
   localparam logic [15:0] DATA_OFFSET_RESET = 16'd512;

   localparam logic [7:0]  ID_MARK  = 8'ha1;
   localparam logic [7:0]  ID_TAG   = 8'hfe;
   localparam logic [15:0] CRC_INIT = 16'hffff;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   localparam int REM_STEPS = 9;
   localparam int CRC_BYTES = 6;
   localparam int MUL_STEPS = 3;

   typedef enum logic [1:0] {
      ALU_MULADD  = 2'd0,
      ALU_REMSTEP = 2'd1,
      ALU_CRCBYTE = 2'd2
   } alu_op_type;

   typedef struct packed {
      alu_op_type  op;
      logic [31:0] a;
      logic [15:0] b;
      logic [15:0] c;
   } alu_ctl_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] cylinder;
      logic [7:0]  head;
      logic [7:0]  sector;
      logic [7:0]  first_sector;
      logic [7:0]  track_sectors;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] byte_offset;
      logic [63:0] header_word;
      logic        label_changed;
      logic [16:0] cylinder_count;
      logic [8:0]  head_count;
      logic [8:0]  sectors_per_track;
      logic        is_formatted;
   } rsp_type;

   // one byte of CRC-16-CCITT, msb first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// File: hdl/dgh_alu.sv
`default_nettype none

module dgh_alu
   import dgh_pkg::*;
(
   input  wire alu_ctl_type ctl,
   output logic [31:0]      result
);

   logic [47:0] product;
   logic [9:0]  rem_shift;
   logic [9:0]  divisor;

   assign product   = ctl.a * {32'd0, ctl.b};
   assign rem_shift = {ctl.a[8:0], ctl.c[0]};
   assign divisor   = {1'b0, ctl.b[8:0]};

   always_comb begin
      unique case (ctl.op)
         ALU_MULADD: begin
            result = product[31:0] + {16'd0, ctl.c};
         end
         ALU_REMSTEP: begin
            // restoring step: keep the partial remainder below the divisor
            if (rem_shift >= divisor) begin
               result = {22'd0, rem_shift - divisor};
            end else begin
               result = {22'd0, rem_shift};
            end
         end
         ALU_CRCBYTE: begin
            result = {16'd0, crc_byte(ctl.a[15:0], ctl.c[7:0])};
         end
         default: begin
            result = 32'd0;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: hdl/disk_geometry_and_header_engine.sv
// Access: three multiply-add passes through the shared unit, Horner form.
// Read header: nine remainder steps for the position, then one CRC byte per cycle over six bytes.
// Format, errors and the unused code go straight from decode to the output register.
// A request is held until its reply is in the output register; only then is a new one taken.
// Synchronous active-high reset: geometry cleared, sector size and data offset to 512.
`default_nettype none

module disk_geometry_and_header_engine
   import dgh_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   input  wire          req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire          rsp_stall,
   output rsp_type      rsp_data,
   input  wire          csr_write,
   input  wire          csr_index,
   input  wire [15:0]   csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MUL,
      ST_REM,
      ST_CRC,
      ST_FINISH
   } state_type;

   state_type   state_ff;
   req_type     req_ff;
   logic [3:0]  step_ff;
   logic [31:0] acc_ff;
   logic [1:0]  status_ff;
   logic        changed_ff;
   logic        hdr_ok_ff;
   logic [7:0]  secnum_ff;

   logic [15:0] sector_size_ff;
   logic [15:0] data_offset_ff;
   logic [16:0] geom_cyl_ff;
   logic [8:0]  geom_heads_ff;
   logic [8:0]  geom_spt_ff;
   logic        formatted_ff;
   logic [7:0]  first_sec_ff;
   logic [8:0]  header_pos_ff;

   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   alu_ctl_type alu_ctl;
   logic [31:0] alu_res;
   logic [7:0]  id_byte;
   logic [3:0]  bit_sel;
   logic        req_accept;
   logic        out_of_range;
   logic        sec_grow;
   logic        head_grow;
   logic        cyl_grow;
   rsp_type     rsp_in;

   assign req_stall  = reset || (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   assign sec_grow  = ({1'b0, req_ff.sector} >= geom_spt_ff);
   assign head_grow = ({1'b0, req_ff.head} >= geom_heads_ff);
   assign cyl_grow  = ({1'b0, req_ff.cylinder} >= geom_cyl_ff);
   assign out_of_range = sec_grow || head_grow || cyl_grow;

   assign bit_sel = 4'(REM_STEPS - 1) - step_ff;

   always_comb begin
      unique case (step_ff)
         4'd0:    id_byte = ID_MARK;
         4'd1:    id_byte = ID_TAG;
         4'd2:    id_byte = req_ff.cylinder[7:0];
         4'd3:    id_byte = req_ff.cylinder[15:8];
         4'd4:    id_byte = req_ff.head;
         default: id_byte = secnum_ff;
      endcase
   end

   always_comb begin
      alu_ctl = '{op: ALU_MULADD, a: acc_ff, b: 16'd0, c: 16'd0};
      unique case (state_ff)
         ST_MUL: begin
            unique case (step_ff)
               4'd0: begin
                  alu_ctl.b = {7'd0, geom_heads_ff};
                  alu_ctl.c = {8'd0, req_ff.head};
               end
               4'd1: begin
                  alu_ctl.b = {7'd0, geom_spt_ff};
                  alu_ctl.c = {8'd0, req_ff.sector};
               end
               default: begin
                  alu_ctl.b = sector_size_ff;
                  alu_ctl.c = data_offset_ff;
               end
            endcase
         end
         ST_REM: begin
            alu_ctl.op = ALU_REMSTEP;
            alu_ctl.b  = {7'd0, geom_spt_ff};
            alu_ctl.c  = {15'd0, header_pos_ff[bit_sel]};
         end
         ST_CRC: begin
            alu_ctl.op = ALU_CRCBYTE;
            alu_ctl.c  = {8'd0, id_byte};
         end
         default: begin
         end
      endcase
   end

   dgh_alu u_alu (
      .ctl    (alu_ctl),
      .result (alu_res)
   );

   always_comb begin
      rsp_in.status            = status_ff;
      rsp_in.byte_offset       = (req_ff.operation == OP_ACCESS) ? acc_ff : 32'd0;
      rsp_in.header_word       = hdr_ok_ff ?
         {ID_MARK, ID_TAG, req_ff.cylinder[7:0], req_ff.cylinder[15:8], req_ff.head,
          secnum_ff, acc_ff[15:0]} : 64'd0;
      rsp_in.label_changed     = changed_ff;
      rsp_in.cylinder_count    = geom_cyl_ff;
      rsp_in.head_count        = geom_heads_ff;
      rsp_in.sectors_per_track = geom_spt_ff;
      rsp_in.is_formatted      = formatted_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sector_size_ff <= SECTOR_SIZE_RESET;
         data_offset_ff <= DATA_OFFSET_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SECTOR_SIZE: sector_size_ff <= csr_wdata;
            CSR_DATA_OFFSET: data_offset_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= 4'd0;
         rsp_valid_ff  <= 1'b0;
         geom_cyl_ff   <= 17'd0;
         geom_heads_ff <= 9'd0;
         geom_spt_ff   <= 9'd0;
         formatted_ff  <= 1'b0;
         first_sec_ff  <= 8'd0;
         header_pos_ff <= 9'd0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  req_ff   <= req_data;
                  state_ff <= ST_DECODE;
               end
            end
            ST_DECODE: begin
               status_ff  <= STATUS_OK;
               changed_ff <= 1'b0;
               hdr_ok_ff  <= 1'b0;
               acc_ff     <= 32'd0;
               step_ff    <= 4'd0;
               state_ff   <= ST_FINISH;
               unique case (req_ff.operation)
                  OP_ACCESS: begin
                     if (sector_size_ff == 16'd0) begin
                        status_ff <= STATUS_NOSIZE;
                        acc_ff    <= {16'd0, data_offset_ff};
                     end else if (formatted_ff && out_of_range) begin
                        status_ff <= STATUS_RANGE;
                     end else begin
                        if (!formatted_ff) begin
                           if (sec_grow) begin
                              geom_spt_ff <= {1'b0, req_ff.sector} + 9'd1;
                           end
                           if (head_grow) begin
                              geom_heads_ff <= {1'b0, req_ff.head} + 9'd1;
                           end
                           if (cyl_grow) begin
                              geom_cyl_ff <= {1'b0, req_ff.cylinder} + 17'd1;
                           end
                           changed_ff <= out_of_range;
                        end
                        acc_ff   <= {16'd0, req_ff.cylinder};
                        state_ff <= ST_MUL;
                     end
                  end
                  OP_HEADER: begin
                     if (!formatted_ff || cyl_grow || head_grow || geom_spt_ff == 9'd0) begin
                        status_ff <= STATUS_RANGE;
                     end else begin
                        state_ff <= ST_REM;
                     end
                  end
                  OP_FORMAT: begin
                     first_sec_ff <= req_ff.first_sector;
                     if (req_ff.track_sectors != 8'd0) begin
                        geom_spt_ff <= {1'b0, req_ff.track_sectors};
                     end
                     if (head_grow) begin
                        geom_heads_ff <= {1'b0, req_ff.head} + 9'd1;
                     end
                     if (cyl_grow) begin
                        geom_cyl_ff <= {1'b0, req_ff.cylinder} + 17'd1;
                     end
                     formatted_ff <= 1'b1;
                     changed_ff   <= 1'b1;
                  end
                  default: begin
                     status_ff <= STATUS_RANGE;
                  end
               endcase
            end
            ST_MUL: begin
               acc_ff  <= alu_res;
               step_ff <= step_ff + 4'd1;
               if (step_ff == 4'(MUL_STEPS - 1)) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_REM: begin
               acc_ff  <= alu_res;
               step_ff <= step_ff + 4'd1;
               if (step_ff == 4'(REM_STEPS - 1)) begin
                  // remainder is the sector; advance the position past it
                  header_pos_ff <= alu_res[8:0] + 9'd1;
                  secnum_ff     <= alu_res[7:0] + first_sec_ff;
                  acc_ff        <= {16'd0, CRC_INIT};
                  step_ff       <= 4'd0;
                  state_ff      <= ST_CRC;
               end
            end
            ST_CRC: begin
               acc_ff  <= alu_res;
               step_ff <= step_ff + 4'd1;
               if (step_ff == 4'(CRC_BYTES - 1)) begin
                  hdr_ok_ff <= 1'b1;
                  state_ff  <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               // hold until the output register is free
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_ff       <= rsp_in;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   a_formatted_sticky: assert property (@(posedge clock) disable iff (reset)
      formatted_ff |=> formatted_ff)
      else $error("formatted flag dropped");

   a_position_bound: assert property (@(posedge clock) disable iff (reset)
      header_pos_ff <= 9'd256)
      else $error("header position beyond a full track");

   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ST_DECODE)
      else $error("accepted request not decoded");

   a_formatted_no_grow: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECODE && req_ff.operation == OP_ACCESS && formatted_ff)
      |=> ($stable(geom_cyl_ff) && $stable(geom_heads_ff) && $stable(geom_spt_ff)))
      else $error("geometry changed by access on a formatted drive");

   a_header_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.header_word != 64'd0) |-> rsp_ff.status == STATUS_OK)
      else $error("header returned with an error status");

endmodule

`default_nettype wire

// File: tb/tb_disk_geometry_and_header_engine.sv
module tb_disk_geometry_and_header_engine;
   timeunit 1ns;
   timeprecision 1ps;

   import dgh_pkg::*;

   localparam logic [1:0]  OP_UNUSED      = 2'd3;
   localparam int          WATCHDOG_LIMIT = 2000;
   localparam logic [63:0] LOW32          = 64'h0000_0000_ffff_ffff;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write = 1'b0;
   logic        csr_index = CSR_SECTOR_SIZE;
   logic [15:0] csr_wdata = '0;

   // drive side and check side
   req_type disk_requests[$];
   rsp_type disk_replies[$];

   // register copies and drive geometry as the block should hold them
   logic [15:0] cfg_sector_size = SECTOR_SIZE_RESET;
   logic [15:0] cfg_data_offset = DATA_OFFSET_RESET;
   logic [16:0] geo_cyls  = '0;
   logic [8:0]  geo_heads = '0;
   logic [8:0]  geo_spt   = '0;
   logic        fmt_done  = 1'b0;
   logic [7:0]  fmt_first = '0;
   logic [8:0]  hdr_pos   = '0;

   int cycle_count  = 0;
   int stuck_cycles = 0;
   int hold_left    = 0;
   int mismatches   = 0;
   int replies_seen = 0;
   int settings     = 0;
   int op_seen[4]   = '{0, 0, 0, 0};
   int headers_ok   = 0;
   int range_fails  = 0;
   int size_unset   = 0;

   logic quiet;
   logic req_fire;
   logic rsp_fire;

   assign quiet    = (cycle_count % 3000) < 600;
   assign req_fire = req_valid && !req_stall;
   assign rsp_fire = rsp_valid && !rsp_stall;

   disk_geometry_and_header_engine i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // advance the drive state by one request and return the reply it must give
   function automatic rsp_type step_disk_geometry(input req_type rq);
      rsp_type     rp;
      logic [63:0] ss;
      logic [63:0] acc;
      logic [47:0] id_bytes;
      logic [15:0] crc;
      logic [8:0]  slot;
      logic        fb;
      rp = '0;
      op_seen[rq.operation]++;
      case (rq.operation)
         OP_ACCESS: begin
            if (cfg_sector_size == 16'd0) begin
               rp.status      = STATUS_NOSIZE;
               rp.byte_offset = 32'(cfg_data_offset);
               size_unset++;
            end else if (fmt_done && (9'(rq.sector) >= geo_spt || 9'(rq.head) >= geo_heads ||
                                      17'(rq.cylinder) >= geo_cyls)) begin
               rp.status = STATUS_RANGE;
               range_fails++;
            end else begin
               if (!fmt_done) begin
                  if (9'(rq.sector) + 9'd1 > geo_spt) begin
                     geo_spt = 9'(rq.sector) + 9'd1;
                     rp.label_changed = 1'b1;
                  end
                  if (9'(rq.head) + 9'd1 > geo_heads) begin
                     geo_heads = 9'(rq.head) + 9'd1;
                     rp.label_changed = 1'b1;
                  end
                  if (17'(rq.cylinder) + 17'd1 > geo_cyls) begin
                     geo_cyls = 17'(rq.cylinder) + 17'd1;
                     rp.label_changed = 1'b1;
                  end
               end
               ss  = 64'(cfg_sector_size);
               acc = 64'(cfg_data_offset) + 64'(rq.sector) * ss;
               acc = acc + ((64'(rq.head) * ss) & LOW32) * 64'(geo_spt);
               acc = acc & LOW32;
               acc = acc + ((((64'(rq.cylinder) * ss) & LOW32) * 64'(geo_spt)) & LOW32)
                           * 64'(geo_heads);
               rp.byte_offset = acc[31:0];
            end
         end
         OP_HEADER: begin
            if (!fmt_done || 17'(rq.cylinder) >= geo_cyls || 9'(rq.head) >= geo_heads ||
                geo_spt == 9'd0) begin
               rp.status = STATUS_RANGE;
               range_fails++;
            end else begin
               slot     = hdr_pos % geo_spt;
               hdr_pos  = slot + 9'd1;
               id_bytes = {ID_MARK, ID_TAG, rq.cylinder[7:0], rq.cylinder[15:8], rq.head,
                           slot[7:0] + fmt_first};
               // serial CCITT over the six id bytes, msb first
               crc = CRC_INIT;
               for (int b = 47; b >= 0; b--) begin
                  fb  = crc[15] ^ id_bytes[b];
                  crc = {crc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
               end
               rp.header_word = {id_bytes, crc};
               headers_ok++;
            end
         end
         OP_FORMAT: begin
            fmt_first = rq.first_sector;
            if (rq.track_sectors != 8'd0)
               geo_spt = 9'(rq.track_sectors);
            if (17'(rq.cylinder) + 17'd1 > geo_cyls)
               geo_cyls = 17'(rq.cylinder) + 17'd1;
            if (9'(rq.head) + 9'd1 > geo_heads)
               geo_heads = 9'(rq.head) + 9'd1;
            fmt_done         = 1'b1;
            rp.label_changed = 1'b1;
         end
         default: begin
            rp.status = STATUS_RANGE;
         end
      endcase
      rp.cylinder_count    = geo_cyls;
      rp.head_count        = geo_heads;
      rp.sectors_per_track = geo_spt;
      rp.is_formatted      = fmt_done;
      return rp;
   endfunction

   function automatic req_type random_request(input bit formatted);
      req_type rq;
      int      pick;
      rq.cylinder      = 16'($urandom_range(0, 65535));
      rq.head          = 8'($urandom_range(0, 255));
      rq.sector        = 8'($urandom_range(0, 255));
      rq.first_sector  = 8'($urandom_range(0, 255));
      rq.track_sectors = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (!formatted) begin
         // keep the grown geometry modest so formatted range checks stay reachable
         if (pick < 80)
            rq.operation = OP_ACCESS;
         else if (pick < 90)
            rq.operation = OP_HEADER;
         else
            rq.operation = OP_UNUSED;
         rq.cylinder = 16'($urandom_range(0, 399));
         rq.head     = 8'($urandom_range(0, 11));
      end else begin
         if (pick < 45)
            rq.operation = OP_ACCESS;
         else if (pick < 80)
            rq.operation = OP_HEADER;
         else if (pick < 93)
            rq.operation = OP_FORMAT;
         else
            rq.operation = OP_UNUSED;
         if (rq.operation == OP_FORMAT) begin
            rq.cylinder = 16'($urandom_range(0, 399));
            rq.head     = 8'($urandom_range(0, 11));
            pick = $urandom_range(0, 99);
            if (pick < 10)
               rq.track_sectors = 8'd0;
            else if (pick < 15)
               rq.track_sectors = 8'd255;
            else
               rq.track_sectors = 8'($urandom_range(1, 40));
         end else begin
            if ($urandom_range(0, 9) != 0)
               rq.cylinder = 16'($urandom_range(0, 450));
            if ($urandom_range(0, 9) != 0)
               rq.head = 8'($urandom_range(0, 13));
            if ($urandom_range(0, 99) < 85)
               rq.sector = 8'($urandom_range(0, 45));
         end
      end
      return rq;
   endfunction

   task automatic queue_req(input logic [1:0] op, input int cyl, input int hd, input int sec,
                            input int fsec, input int tsec);
      req_type rq;
      rq.operation     = op;
      rq.cylinder      = 16'(cyl);
      rq.head          = 8'(hd);
      rq.sector        = 8'(sec);
      rq.first_sector  = 8'(fsec);
      rq.track_sectors = 8'(tsec);
      disk_requests.push_back(rq);
   endtask

   // wait until every request has been taken and answered
   task automatic settle();
      do
         @(negedge clock);
      while (disk_requests.size() != 0 || req_valid || disk_replies.size() != 0);
   endtask

   task automatic set_registers(input logic [15:0] size, input logic [15:0] offs);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_SECTOR_SIZE;
      csr_wdata <= size;
      @(posedge clock);
      csr_index <= CSR_DATA_OFFSET;
      csr_wdata <= offs;
      @(posedge clock);
      csr_write <= 1'b0;
      cfg_sector_size = size;
      cfg_data_offset = offs;
      settings++;
      @(negedge clock);
   endtask

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("reply %0d: %s expected %h, got %h", replies_seen, name, want, got);
      end
   endtask

   task automatic check_reply(input rsp_type got);
      rsp_type want;
      replies_seen++;
      if (disk_replies.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("reply %0d arrived with no request outstanding: %h", replies_seen, got);
         return;
      end
      want = disk_replies.pop_front();
      compare_field("status", 64'(want.status), 64'(got.status));
      compare_field("byte_offset", 64'(want.byte_offset), 64'(got.byte_offset));
      compare_field("header_word", want.header_word, got.header_word);
      compare_field("label_changed", 64'(want.label_changed), 64'(got.label_changed));
      compare_field("cylinder_count", 64'(want.cylinder_count), 64'(got.cylinder_count));
      compare_field("head_count", 64'(want.head_count), 64'(got.head_count));
      compare_field("sectors_per_track", 64'(want.sectors_per_track),
                    64'(got.sectors_per_track));
      compare_field("is_formatted", 64'(want.is_formatted), 64'(got.is_formatted));
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_fire)
            disk_replies.push_back(step_disk_geometry(req_data));
         if (!req_valid || !req_stall) begin
            if (disk_requests.size() != 0 && (quiet || $urandom_range(0, 99) >= 34)) begin
               req_data  <= disk_requests.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // reply monitor and receiver stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else begin
         if (rsp_fire)
            check_reply(rsp_data);
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
         end else if (cycle_count % 4000 == 1500) begin
            // hold off long enough to back the block up into its request side
            rsp_stall <= 1'b1;
            hold_left <= 300;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(0, 99) < 34);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset || req_fire || rsp_fire)
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == WATCHDOG_LIMIT) begin
         $display("watchdog: no traffic for %0d cycles", WATCHDOG_LIMIT);
         $display("tb_disk_geometry_and_header_engine: done, errors");
         $finish;
      end
   end

   initial begin
      logic [15:0] size;
      logic [15:0] offs;
      int          count;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // unformatted drive at reset register values: no header, unused code, growth
      queue_req(OP_HEADER, 0, 0, 0, 0, 0);
      queue_req(OP_UNUSED, 0, 0, 0, 0, 0);
      queue_req(OP_ACCESS, 0, 0, 0, 0, 0);
      queue_req(OP_ACCESS, 5, 2, 7, 0, 0);
      queue_req(OP_ACCESS, 1, 1, 1, 0, 0);
      queue_req(OP_ACCESS, 399, 11, 255, 0, 0);
      settle();

      // sector size unset: offset is the data offset, geometry untouched
      set_registers(16'd0, 16'hffff);
      queue_req(OP_ACCESS, 3, 3, 3, 0, 0);
      queue_req(OP_ACCESS, 65535, 255, 255, 255, 255);
      settle();

      set_registers(16'd1, 16'd0);
      repeat (200) disk_requests.push_back(random_request(1'b0));
      settle();

      // formatting is sticky, so a header read with zero sectors per track
      // cannot follow the unformatted growth above
      set_registers(16'hffff, 16'hffff);
      queue_req(OP_FORMAT, 2, 1, 0, 8'hf0, 0);
      queue_req(OP_HEADER, 2, 1, 0, 0, 0);
      queue_req(OP_HEADER, 0, 0, 0, 0, 0);
      queue_req(OP_FORMAT, 7, 3, 0, 254, 3);
      repeat (4) queue_req(OP_HEADER, 1, 2, 0, 0, 0);
      queue_req(OP_ACCESS, 399, 11, 2, 0, 0);
      queue_req(OP_ACCESS, 0, 0, 3, 0, 0);
      queue_req(OP_ACCESS, 65535, 0, 0, 0, 0);
      queue_req(OP_ACCESS, 0, 255, 0, 0, 0);
      queue_req(OP_HEADER, 65535, 0, 0, 0, 0);
      queue_req(OP_HEADER, 0, 200, 0, 0, 0);
      queue_req(OP_UNUSED, 0, 0, 0, 0, 0);
      settle();

      for (int p = 0; p < 6; p++) begin
         offs  = 16'($urandom_range(0, 65535));
         count = 200;
         case (p)
            0: size = 16'd512;
            1: begin
               size = 16'($urandom_range(1, 65535));
               offs = 16'd0;
            end
            2: begin
               size  = 16'd0;
               count = 60;
            end
            3: begin
               size = 16'hffff;
               offs = 16'hffff;
            end
            4: size = 16'($urandom_range(1, 4096));
            default: size = 16'd1;
         endcase
         set_registers(size, offs);
         repeat (count) disk_requests.push_back(random_request(1'b1));
         settle();
      end

      // full-size geometry and wrapping offsets
      set_registers(16'hffff, 16'd0);
      queue_req(OP_FORMAT, 65535, 255, 0, 255, 255);
      queue_req(OP_ACCESS, 65535, 255, 254, 0, 0);
      queue_req(OP_HEADER, 65535, 255, 0, 0, 0);
      queue_req(OP_ACCESS, 0, 0, 255, 0, 0);
      settle();
      repeat (20) @(posedge clock);

      $display("covered %0d access, %0d header, %0d format, %0d unused requests over %0d settings",
               op_seen[OP_ACCESS], op_seen[OP_HEADER], op_seen[OP_FORMAT], op_seen[OP_UNUSED],
               settings);
      $display("%0d headers returned, %0d range rejects, %0d size-unset accesses, %0d replies",
               headers_ok, range_fails, size_unset, replies_seen);
      if (mismatches == 0 && disk_replies.size() == 0) begin
         $display("tb_disk_geometry_and_header_engine: done, clean");
      end else begin
         $display("%0d mismatches, %0d replies missing", mismatches, disk_replies.size());
         $display("tb_disk_geometry_and_header_engine: done, errors");
      end
      $finish;
   end

endmodule
